### design/rect_region_allocator_macros.svh
// ----------------------------------------------------------------------------
// rect_region_allocator assertion macros
// concurrent assertion helpers, removed when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef RECT_REGION_ALLOCATOR_MACROS_SVH
`define RECT_REGION_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

`define RRA_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define RRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define RRA_ASSERT_ALWAYS(label, clk, rst, prop)

`define RRA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/rra_pkg.sv
// ----------------------------------------------------------------------------
// rra_pkg
// shared types and constants of the rectangle region allocator
// ----------------------------------------------------------------------------
package rra_pkg;

   localparam int MAX_TILES = 32;
   localparam int ATLAS_MAX = 4096;
   localparam int IDX_W     = $clog2(MAX_TILES);
   localparam int CNT_W     = $clog2(MAX_TILES + 1);
   localparam int COORD_W   = $clog2(ATLAS_MAX);
   localparam int SIZE_W    = $clog2(ATLAS_MAX) + 1;
   localparam int EDGE_W    = SIZE_W + 1;
   localparam int ALIGN_W   = 2;
   localparam logic [ALIGN_W-1:0] ALIGN_MASK = 2'h3;

   localparam logic [SIZE_W-1:0] ATLAS_RESET = SIZE_W'(ATLAS_MAX);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_ALIGNED = 2'd2;

   typedef enum logic [1:0] {
      REQ_ALLOC    = 2'd0,
      REQ_FREE     = 2'd1,
      REQ_FREE_ALL = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic [COORD_W-1:0] left_edge;
      logic [COORD_W-1:0] top_edge;
      logic [EDGE_W-1:0]  right_edge;
      logic [EDGE_W-1:0]  bottom_edge;
   } entry_type;

   typedef struct packed {
      logic live;
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

### design/rect_region_allocator.sv
// ----------------------------------------------------------------------------
// rect_region_allocator
// table of rectangles placed on a 2D atlas, built as a row of slot cells
// ----------------------------------------------------------------------------
// requests arrive on req_* (valid/ready); each produces one response on
// rsp_* (valid/ready) with ok, the new slot index of an allocation and the
// number of entries in use afterwards.
// an allocate is appended at the end of the table when it is non-empty,
// aligned if block_aligned is set, inside the atlas, free of overlap and
// the table has room; a free removes one slot and every later slot moves
// down one place in the same cycle; a free-all empties the table.
// the request is captured, then every cell runs the overlap test in
// parallel and registers its hit flag, then the decision is made with
// the table update; a new request is taken only after the decision.
// a request is taken while the previous response still waits; the decision
// holds until the output register is free, so a stalled receiver stops
// the block after one request.
// csr_* writes the atlas size and alignment mode; the user writes it only
// while idle, which the block itself does not enforce.
// reset (synchronous) empties the table and restores a 4096 x 4096 atlas
// with alignment off; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "rect_region_allocator_macros.svh"

module rect_region_allocator import rra_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [COORD_W-1:0]   req_rect_left,
   input  logic [COORD_W-1:0]   req_rect_top,
   input  logic [SIZE_W-1:0]    req_rect_width,
   input  logic [SIZE_W-1:0]    req_rect_height,
   input  logic [IDX_W-1:0]     req_free_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output logic [IDX_W-1:0]     rsp_new_index,
   output logic [CNT_W-1:0]     rsp_tiles_in_use,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DECIDE
   } state_type;

   typedef struct packed {
      req_kind_type       kind;
      logic [COORD_W-1:0] left_edge;
      logic [COORD_W-1:0] top_edge;
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic [IDX_W-1:0]   free_index;
   } request_type;

   state_type          state_ff, state_in;
   request_type        req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [SIZE_W-1:0]  atlas_width_ff, atlas_width_in;
   logic [SIZE_W-1:0]  atlas_height_ff, atlas_height_in;
   logic               block_aligned_ff, block_aligned_in;
   logic               basic_ok_ff, basic_ok_in;

   entry_type          req_entry;
   entry_type          cell_entry [MAX_TILES];
   entry_type          cell_next [MAX_TILES];
   cell_ctl_type       cell_ctl [MAX_TILES];
   logic [MAX_TILES-1:0] hit_vec;
   logic [MAX_TILES-1:0] load_vec;
   logic               req_xfer;
   logic               fire;
   logic               alloc_ok;
   logic               free_ok;
   logic               load_en;
   logic               shift_en;
   logic [ALIGN_W-1:0] low_bits;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign fire      = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ready);

   // request rectangle with its far edges, seen by every cell
   always_comb begin
      req_entry.left_edge   = req_ff.left_edge;
      req_entry.top_edge    = req_ff.top_edge;
      req_entry.right_edge  = EDGE_W'(req_ff.left_edge) + EDGE_W'(req_ff.width);
      req_entry.bottom_edge = EDGE_W'(req_ff.top_edge) + EDGE_W'(req_ff.height);
      low_bits = req_ff.left_edge[ALIGN_W-1:0] | req_ff.top_edge[ALIGN_W-1:0] |
                 req_ff.width[ALIGN_W-1:0] | req_ff.height[ALIGN_W-1:0];
      basic_ok_in = (req_ff.width != '0) && (req_ff.height != '0) &&
                    !(block_aligned_ff && ((low_bits & ALIGN_MASK) != '0)) &&
                    (req_entry.right_edge <= EDGE_W'(atlas_width_ff)) &&
                    (req_entry.bottom_edge <= EDGE_W'(atlas_height_ff));
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_TILES; gi++) begin : g_cell
         assign cell_ctl[gi].live  = (CNT_W'(gi) < count_ff);
         assign cell_ctl[gi].load  = load_en && (IDX_W'(gi) == count_ff[IDX_W-1:0]);
         assign cell_ctl[gi].shift = shift_en && (IDX_W'(gi) >= req_ff.free_index);
         assign load_vec[gi]       = cell_ctl[gi].load;
         if (gi == MAX_TILES - 1) begin : g_last
            assign cell_next[gi] = req_entry;
         end else begin : g_mid
            assign cell_next[gi] = cell_entry[gi + 1];
         end
         rra_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[gi]),
            .req_entry  (req_entry),
            .next_entry (cell_next[gi]),
            .entry      (cell_entry[gi]),
            .hit        (hit_vec[gi])
         );
      end
   endgenerate

   always_comb begin
      alloc_ok = basic_ok_ff && (hit_vec == '0) && (count_ff < CNT_W'(MAX_TILES));
      free_ok  = (CNT_W'(req_ff.free_index) < count_ff);
      load_en      = 1'b0;
      shift_en     = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_index_in = '0;
      count_in     = count_ff;
      case (req_ff.kind)
         REQ_ALLOC: begin
            rsp_ok_in = alloc_ok;
            load_en   = fire && alloc_ok;
            if (alloc_ok) begin
               rsp_index_in = count_ff[IDX_W-1:0];
               count_in     = count_ff + CNT_W'(1);
            end
         end
         REQ_FREE: begin
            rsp_ok_in = free_ok;
            shift_en  = fire && free_ok;
            if (free_ok) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_FREE_ALL: begin
            rsp_ok_in = 1'b1;
            count_in  = '0;
         end
         default: begin
            rsp_ok_in = 1'b0;
         end
      endcase
      rsp_count_in = count_in;
      if (!fire) begin
         count_in = count_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_xfer) state_in = S_CHECK;
         S_CHECK:  state_in = S_DECIDE;
         S_DECIDE: if (fire) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      req_in = req_ff;
      if (req_xfer) begin
         req_in.kind       = req_kind_type'(req_type);
         req_in.left_edge  = req_rect_left;
         req_in.top_edge   = req_rect_top;
         req_in.width      = req_rect_width;
         req_in.height     = req_rect_height;
         req_in.free_index = req_free_index;
      end

      atlas_width_in   = atlas_width_ff;
      atlas_height_in  = atlas_height_ff;
      block_aligned_in = block_aligned_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_ATLAS_WIDTH:   atlas_width_in   = csr_wdata;
            CSR_ATLAS_HEIGHT:  atlas_height_in  = csr_wdata;
            CSR_BLOCK_ALIGNED: block_aligned_in = csr_wdata[0];
            default:           block_aligned_in = block_aligned_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         count_ff         <= '0;
         atlas_width_ff   <= ATLAS_RESET;
         atlas_height_ff  <= ATLAS_RESET;
         block_aligned_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         count_ff         <= count_in;
         atlas_width_ff   <= atlas_width_in;
         atlas_height_ff  <= atlas_height_in;
         block_aligned_ff <= block_aligned_in;
         req_ff           <= req_in;
         basic_ok_ff      <= basic_ok_in;
         if (fire) begin
            rsp_ok_ff    <= rsp_ok_in;
            rsp_index_ff <= rsp_index_in;
            rsp_count_ff <= rsp_count_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_new_index    = rsp_index_ff;
   assign rsp_tiles_in_use = rsp_count_ff;

   `RRA_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(MAX_TILES))
   `RRA_ASSERT_ALWAYS(a_single_load, clock, reset, $onehot0(load_vec))
   `RRA_ASSERT_NEXT(a_fire_rsp, clock, reset, fire, rsp_valid_ff && (state_ff == S_IDLE))
   `RRA_ASSERT_NEXT(a_alloc_count, clock, reset, fire && load_en, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

### design/rra_cell.sv
// ----------------------------------------------------------------------------
// rra_cell
// one table slot: holds a rectangle, tests it against the request and
// takes the request or its upper neighbor's rectangle
// ----------------------------------------------------------------------------
module rra_cell import rra_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    req_entry,
   input  entry_type    next_entry,
   output entry_type    entry,
   output logic         hit
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      hit_ff;
   logic      hit_in;
   logic      apart;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = req_entry;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
      // touching edges do not count as overlap
      apart = (EDGE_W'(entry_ff.left_edge) >= req_entry.right_edge) ||
              (entry_ff.right_edge <= EDGE_W'(req_entry.left_edge)) ||
              (EDGE_W'(entry_ff.top_edge) >= req_entry.bottom_edge) ||
              (entry_ff.bottom_edge <= EDGE_W'(req_entry.top_edge));
      hit_in = ctl.live && !apart;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule
